>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion macros for the box/triangle overlap test unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BTOT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BTOT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BTOT_ASSERT_IMPL(label, ante, cons)
`define BTOT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> sv/btot_pkg.sv
// ----------------------------------------------------------------------------
// Box/triangle overlap test package
// Field type and point ordering shared by the pipeline modules.
// ----------------------------------------------------------------------------
package btot_pkg;

	localparam int FIELD_W = 48;
	localparam int NUM_PTS = 5;

	// Point order inside the pipeline.
	localparam int PT_LO = 0;
	localparam int PT_HI = 1;
	localparam int PT_A  = 2;
	localparam int PT_B  = 3;
	localparam int PT_C  = 4;

	typedef logic [FIELD_W-1:0] field_t;

endpackage

>>> sv/btot_front.sv
// ----------------------------------------------------------------------------
// Front stage
// Unpacks the coordinates, forms the triangle edges and runs the bounding
// box check against the box.
// ----------------------------------------------------------------------------
module btot_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  btot_pkg::field_t             fields [btot_pkg::NUM_PTS],
	output logic signed [COORD_BITS-1:0] pts_s1 [btot_pkg::NUM_PTS][3],
	output logic signed [COORD_BITS:0]   u_s1 [3],
	output logic signed [COORD_BITS:0]   v_s1 [3],
	output logic signed [COORD_BITS:0]   e_s1 [3][3],
	output logic                         bbox_ok_s1
);
	import btot_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int PW = (3 * C > FIELD_W) ? 3 * C : FIELD_W;
	localparam int DW = C + 1;

	logic [PW-1:0]             pad [NUM_PTS];
	logic signed [C-1:0]       comp [NUM_PTS][3];
	logic signed [DW-1:0]      da [3], db [3], dc [3];
	logic                      bbox_ok;

	always_comb begin
		logic signed [C-1:0] mn, mx;
		for (int p = 0; p < NUM_PTS; p++) begin
			pad[p] = PW'(fields[p]);
			for (int k = 0; k < 3; k++) begin
				comp[p][k] = pad[p][k*C +: C];
			end
		end
		bbox_ok = 1'b1;
		for (int k = 0; k < 3; k++) begin
			da[k] = DW'(comp[PT_A][k]);
			db[k] = DW'(comp[PT_B][k]);
			dc[k] = DW'(comp[PT_C][k]);
			mn = comp[PT_A][k];
			mx = comp[PT_A][k];
			if (comp[PT_B][k] < mn) mn = comp[PT_B][k];
			if (comp[PT_C][k] < mn) mn = comp[PT_C][k];
			if (comp[PT_B][k] > mx) mx = comp[PT_B][k];
			if (comp[PT_C][k] > mx) mx = comp[PT_C][k];
			if (comp[PT_HI][k] < mn || comp[PT_LO][k] > mx) bbox_ok = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pts_s1     <= comp;
			bbox_ok_s1 <= bbox_ok;
			for (int k = 0; k < 3; k++) begin
				u_s1[k]    <= db[k] - da[k];
				v_s1[k]    <= dc[k] - da[k];
				e_s1[0][k] <= da[k] - db[k];
				e_s1[1][k] <= db[k] - dc[k];
				e_s1[2][k] <= dc[k] - da[k];
			end
		end
	end

endmodule

>>> sv/btot_edge.sv
// ----------------------------------------------------------------------------
// Edge axis tests
// Projects box and triangle on the nine unit-axis by edge cross products
// over the stages products, sums, interval compare and a delay register.
// ----------------------------------------------------------------------------
module btot_edge #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] pts_s1 [btot_pkg::NUM_PTS][3],
	input  logic signed [COORD_BITS:0]   e_s1 [3][3],
	output logic                         edge_ok_s5
);
	import btot_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int AW = C + 1;
	localparam int PE = 2 * C + 1;
	localparam int SE = PE + 2;

	logic signed [AW-1:0] ax [9][3];
	logic signed [PE-1:0] prod_s2 [9][NUM_PTS][3];
	logic signed [SE-1:0] bmin_s3 [9], bmax_s3 [9];
	logic signed [SE-1:0] t_s3 [9][3];
	logic                 edge_ok_s4;
	logic [8:0]           ok;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ax[k][0]     = '0;
			ax[k][1]     = -e_s1[k][2];
			ax[k][2]     = e_s1[k][1];
			ax[3 + k][0] = e_s1[k][2];
			ax[3 + k][1] = '0;
			ax[3 + k][2] = -e_s1[k][0];
			ax[6 + k][0] = -e_s1[k][1];
			ax[6 + k][1] = e_s1[k][0];
			ax[6 + k][2] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 9; m++) begin
				for (int p = 0; p < NUM_PTS; p++) begin
					for (int j = 0; j < 3; j++) begin
						prod_s2[m][p][j] <= PE'(ax[m][j]) * PE'(pts_s1[p][j]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [SE-1:0] smin, smax, st [3];
		if (en) begin
			for (int m = 0; m < 9; m++) begin
				smin = '0;
				smax = '0;
				for (int t = 0; t < 3; t++) st[t] = '0;
				for (int j = 0; j < 3; j++) begin
					if (prod_s2[m][PT_LO][j] < prod_s2[m][PT_HI][j]) begin
						smin = smin + SE'(prod_s2[m][PT_LO][j]);
						smax = smax + SE'(prod_s2[m][PT_HI][j]);
					end else begin
						smin = smin + SE'(prod_s2[m][PT_HI][j]);
						smax = smax + SE'(prod_s2[m][PT_LO][j]);
					end
					for (int t = 0; t < 3; t++) st[t] = st[t] + SE'(prod_s2[m][PT_A + t][j]);
				end
				bmin_s3[m] <= smin;
				bmax_s3[m] <= smax;
				for (int t = 0; t < 3; t++) t_s3[m][t] <= st[t];
			end
		end
	end

	always_comb begin
		logic signed [SE-1:0] tmin, tmax;
		for (int m = 0; m < 9; m++) begin
			tmin = t_s3[m][0];
			tmax = t_s3[m][0];
			for (int t = 1; t < 3; t++) begin
				if (t_s3[m][t] < tmin) tmin = t_s3[m][t];
				if (t_s3[m][t] > tmax) tmax = t_s3[m][t];
			end
			ok[m] = (bmax_s3[m] >= tmin) && (tmax >= bmin_s3[m]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			edge_ok_s4 <= &ok;
			edge_ok_s5 <= edge_ok_s4;
		end
	end

endmodule

>>> sv/btot_normal.sv
// ----------------------------------------------------------------------------
// Normal axis test
// Builds the triangle normal, projects box and triangle on it and gives the
// interval test from the stage five registers.
// ----------------------------------------------------------------------------
module btot_normal #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] pts_s1 [btot_pkg::NUM_PTS][3],
	input  logic signed [COORD_BITS:0]   u_s1 [3],
	input  logic signed [COORD_BITS:0]   v_s1 [3],
	output logic                         normal_ok
);
	import btot_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int UW = 2 * C + 2;
	localparam int NW = UW + 1;
	localparam int PP = NW + C;
	localparam int SW = PP + 2;

	logic signed [UW-1:0] uv_s2 [6];
	logic signed [C-1:0]  pts_s2 [NUM_PTS][3];
	logic signed [C-1:0]  pts_s3 [NUM_PTS][3];
	logic signed [NW-1:0] n_s3 [3];
	logic signed [PP-1:0] q_s4 [NUM_PTS][3];
	logic signed [SW-1:0] bmin_s5, bmax_s5;
	logic signed [SW-1:0] t_s5 [3];
	logic signed [SW-1:0] tmin, tmax;

	always_ff @(posedge clk) begin
		if (en) begin
			uv_s2[0] <= UW'(u_s1[1]) * UW'(v_s1[2]);
			uv_s2[1] <= UW'(u_s1[2]) * UW'(v_s1[1]);
			uv_s2[2] <= UW'(u_s1[2]) * UW'(v_s1[0]);
			uv_s2[3] <= UW'(u_s1[0]) * UW'(v_s1[2]);
			uv_s2[4] <= UW'(u_s1[0]) * UW'(v_s1[1]);
			uv_s2[5] <= UW'(u_s1[1]) * UW'(v_s1[0]);
			pts_s2   <= pts_s1;
			n_s3[0]  <= NW'(uv_s2[0]) - NW'(uv_s2[1]);
			n_s3[1]  <= NW'(uv_s2[2]) - NW'(uv_s2[3]);
			n_s3[2]  <= NW'(uv_s2[4]) - NW'(uv_s2[5]);
			pts_s3   <= pts_s2;
			for (int p = 0; p < NUM_PTS; p++) begin
				for (int j = 0; j < 3; j++) begin
					q_s4[p][j] <= PP'(n_s3[j]) * PP'(pts_s3[p][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] smin, smax, st [3];
		if (en) begin
			smin = '0;
			smax = '0;
			for (int t = 0; t < 3; t++) st[t] = '0;
			for (int j = 0; j < 3; j++) begin
				if (q_s4[PT_LO][j] < q_s4[PT_HI][j]) begin
					smin = smin + SW'(q_s4[PT_LO][j]);
					smax = smax + SW'(q_s4[PT_HI][j]);
				end else begin
					smin = smin + SW'(q_s4[PT_HI][j]);
					smax = smax + SW'(q_s4[PT_LO][j]);
				end
				for (int t = 0; t < 3; t++) st[t] = st[t] + SW'(q_s4[PT_A + t][j]);
			end
			bmin_s5 <= smin;
			bmax_s5 <= smax;
			t_s5    <= st;
		end
	end

	always_comb begin
		tmin = t_s5[0];
		tmax = t_s5[0];
		for (int t = 1; t < 3; t++) begin
			if (t_s5[t] < tmin) tmin = t_s5[t];
			if (t_s5[t] > tmax) tmax = t_s5[t];
		end
		normal_ok = (bmax_s5 >= tmin) && (tmax >= bmin_s5);
	end

endmodule

>>> sv/box_triangle_overlap_test_unit.sv
// ----------------------------------------------------------------------------
// Box/triangle overlap test unit
// Separating-axis overlap test of an axis-aligned box and a triangle.
// ----------------------------------------------------------------------------
// The unit takes one box/triangle item per clock unless the output stalls,
// and returns one overlaps bit per item, in order. The pipeline depth
// is set by the normal axis path: edge differences, edge products, normal,
// normal projection products, projection sums, and the output register.
// A stalled result holds the whole pipeline, so the input stalls only while
// a finished result waits at the output.
module box_triangle_overlap_test_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  btot_pkg::field_t box_low_corner,
	input  btot_pkg::field_t box_high_corner,
	input  btot_pkg::field_t vertex_a,
	input  btot_pkg::field_t vertex_b,
	input  btot_pkg::field_t vertex_c,
	output logic             result_valid,
	input  logic             result_stall,
	output logic             overlaps
);
	import btot_pkg::*;
	`include "assert_macros.svh"

	localparam int C = COORD_BITS;

	field_t              fields [NUM_PTS];
	logic signed [C-1:0] pts_s1 [NUM_PTS][3];
	logic signed [C:0]   u_s1 [3], v_s1 [3];
	logic signed [C:0]   e_s1 [3][3];
	logic                bbox_ok_s1, bbox_ok_s2, bbox_ok_s3, bbox_ok_s4, bbox_ok_s5;
	logic                edge_ok_s5, normal_ok;
	logic                valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic                overlaps_s6;
	logic                adv;

	assign fields[PT_LO] = box_low_corner;
	assign fields[PT_HI] = box_high_corner;
	assign fields[PT_A]  = vertex_a;
	assign fields[PT_B]  = vertex_b;
	assign fields[PT_C]  = vertex_c;

	assign adv          = !(valid_s6 && result_stall);
	assign item_stall   = !adv;
	assign result_valid = valid_s6;
	assign overlaps     = overlaps_s6;

	btot_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.en         (adv),
		.fields     (fields),
		.pts_s1     (pts_s1),
		.u_s1       (u_s1),
		.v_s1       (v_s1),
		.e_s1       (e_s1),
		.bbox_ok_s1 (bbox_ok_s1)
	);

	btot_edge #(.COORD_BITS(COORD_BITS)) u_edge (
		.clk        (clk),
		.en         (adv),
		.pts_s1     (pts_s1),
		.e_s1       (e_s1),
		.edge_ok_s5 (edge_ok_s5)
	);

	btot_normal #(.COORD_BITS(COORD_BITS)) u_normal (
		.clk       (clk),
		.en        (adv),
		.pts_s1    (pts_s1),
		.u_s1      (u_s1),
		.v_s1      (v_s1),
		.normal_ok (normal_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bbox_ok_s2  <= bbox_ok_s1;
			bbox_ok_s3  <= bbox_ok_s2;
			bbox_ok_s4  <= bbox_ok_s3;
			bbox_ok_s5  <= bbox_ok_s4;
			overlaps_s6 <= bbox_ok_s5 && edge_ok_s5 && normal_ok;
		end
	end

	`BTOT_ASSERT_IMPL(a_stall_only_from_output, item_stall, result_valid && result_stall)
	`BTOT_ASSERT_NEXT(a_stage5_moves_to_output, adv && valid_s5, valid_s6)
	`BTOT_ASSERT_NEXT(a_hold_keeps_front, !adv, valid_s1 == $past(valid_s1))

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box/triangle overlap test unit testbench
// Streams box/triangle pairs through the unit with random gaps on both sides
// and compares every overlaps bit with an exact separating-axis prediction.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CB = 16;
	localparam int LIMIT = 400000;

	typedef struct {
		btot_pkg::field_t lo, hi, a, b, c;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	btot_pkg::field_t box_low_corner = '0, box_high_corner = '0;
	btot_pkg::field_t vertex_a = '0, vertex_b = '0, vertex_c = '0;
	logic result_valid;
	logic result_stall = 1'b1;
	logic overlaps;

	pair_t pending_pairs[$];
	bit expected_overlaps[$];
	int failures = 0;
	int cycle_count = 0;
	bit stimulus_done = 1'b0;
	int hold_off = 0;
	bit in_taken = 1'b0;

	box_triangle_overlap_test_unit #(.COORD_BITS(CB)) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic queue_pair(pair_t p);
		pending_pairs = {pending_pairs, p};
	endtask

	task automatic queue_expected(bit v);
		expected_overlaps = {expected_overlaps, v};
	endtask

	function automatic longint comp(btot_pkg::field_t f, int k);
		logic signed [CB-1:0] v;
		v = f[k*CB +: CB];
		return longint'(v);
	endfunction

	function automatic bit axis_touches(longint ax[3], longint lo[3], longint hi[3],
			longint t[3][3]);
		logic signed [127:0] bmin, bmax, tmin, tmax, d;
		longint p, q;
		if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) return 1'b1;
		bmin = 0;
		bmax = 0;
		for (int i = 0; i < 3; i++) begin
			p = ax[i] * lo[i];
			q = ax[i] * hi[i];
			bmin += (p < q) ? p : q;
			bmax += (p < q) ? q : p;
		end
		for (int j = 0; j < 3; j++) begin
			d = 0;
			for (int i = 0; i < 3; i++) d += ax[i] * t[j][i];
			if (j == 0 || d < tmin) tmin = d;
			if (j == 0 || d > tmax) tmax = d;
		end
		return bmax >= tmin && tmax >= bmin;
	endfunction

	function automatic bit predict_overlap(pair_t p);
		longint lo[3], hi[3], t[3][3], e[3][3], u[3], v[3], ax[3], mn, mx;
		for (int i = 0; i < 3; i++) begin
			lo[i] = comp(p.lo, i);
			hi[i] = comp(p.hi, i);
			t[0][i] = comp(p.a, i);
			t[1][i] = comp(p.b, i);
			t[2][i] = comp(p.c, i);
		end
		for (int i = 0; i < 3; i++) begin
			mn = t[0][i];
			mx = t[0][i];
			for (int j = 1; j < 3; j++) begin
				if (t[j][i] < mn) mn = t[j][i];
				if (t[j][i] > mx) mx = t[j][i];
			end
			if (hi[i] < mn || lo[i] > mx) return 1'b0;
			u[i] = t[1][i] - t[0][i];
			v[i] = t[2][i] - t[0][i];
			e[0][i] = t[0][i] - t[1][i];
			e[1][i] = t[1][i] - t[2][i];
			e[2][i] = t[2][i] - t[0][i];
		end
		ax[0] = u[1] * v[2] - u[2] * v[1];
		ax[1] = u[2] * v[0] - u[0] * v[2];
		ax[2] = u[0] * v[1] - u[1] * v[0];
		if (!axis_touches(ax, lo, hi, t)) return 1'b0;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				case (i)
					0: begin ax[0] = 0; ax[1] = -e[k][2]; ax[2] = e[k][1]; end
					1: begin ax[0] = e[k][2]; ax[1] = 0; ax[2] = -e[k][0]; end
					default: begin ax[0] = -e[k][1]; ax[1] = e[k][0]; ax[2] = 0; end
				endcase
				if (!axis_touches(ax, lo, hi, t)) return 1'b0;
			end
		return 1'b1;
	endfunction

	function automatic btot_pkg::field_t pack_point(longint x, longint y, longint z);
		return {z[CB-1:0], y[CB-1:0], x[CB-1:0]};
	endfunction

	function automatic longint rand_coord(int span);
		if ($urandom_range(0, 9) == 0) return longint'($signed(16'($urandom())));
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic btot_pkg::field_t near_point(btot_pkg::field_t base, int span);
		return pack_point(comp(base, 0) + rand_coord(span), comp(base, 1) + rand_coord(span),
			comp(base, 2) + rand_coord(span));
	endfunction

	function automatic int gap_length();
		if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	initial begin
		pair_t p;
		btot_pkg::field_t mx, mn, z;
		mx = pack_point(32767, 32767, 32767);
		mn = pack_point(-32768, -32768, -32768);
		z = '0;
		// Extremes, an all-ones/all-zeros mix, an inverted box, degenerate triangles.
		queue_pair('{mn, mx, mn, mx, pack_point(32767, -32768, 0)});
		queue_pair('{mn, mx, mx, mx, mx});
		queue_pair('{z, z, z, z, z});
		queue_pair('{'1, '1, '1, '0, '1});
		queue_pair('{mx, mn, z, z, z});
		queue_pair('{mx, mn, mn, mx, pack_point(-32768, 32767, 32767)});
		queue_pair('{pack_point(0, 0, 0), pack_point(10, 10, 10),
			pack_point(10, 10, 10), pack_point(20, 20, 20), pack_point(30, 30, 30)});
		queue_pair('{pack_point(0, 0, 0), pack_point(10, 10, 10),
			pack_point(11, 0, 0), pack_point(20, 5, 5), pack_point(15, 9, 1)});
		queue_pair('{pack_point(0, 0, 0), pack_point(10, 10, 10),
			pack_point(20, 0, 5), pack_point(0, 20, 5), pack_point(20, 20, 5)});
		queue_pair('{pack_point(0, 0, 0), pack_point(10, 10, 10),
			pack_point(12, -5, 0), pack_point(-5, 12, 0), pack_point(12, 12, 10)});
		queue_pair('{pack_point(0, 0, 0), pack_point(10, 10, 10),
			pack_point(11, -2, 0), pack_point(-2, 11, 0), pack_point(5, 5, 20)});
		queue_pair('{pack_point(0, 0, 0), pack_point(1, 1, 1),
			pack_point(2, 0, -3), pack_point(0, 2, -3), pack_point(2, 2, 5)});
		for (int n = 0; n < 800; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				p.lo = btot_pkg::field_t'({$urandom(), $urandom()});
				p.hi = btot_pkg::field_t'({$urandom(), $urandom()});
				p.a = btot_pkg::field_t'({$urandom(), $urandom()});
				p.b = btot_pkg::field_t'({$urandom(), $urandom()});
				p.c = btot_pkg::field_t'({$urandom(), $urandom()});
			end else begin
				int s;
				s = ($urandom_range(0, 1) == 0) ? 40 : 8000;
				p.lo = pack_point(rand_coord(s), rand_coord(s), rand_coord(s));
				p.hi = near_point(p.lo, s / 2);
				if ($urandom_range(0, 4) != 0)
					p.hi = pack_point(comp(p.lo, 0) + $urandom_range(0, s),
						comp(p.lo, 1) + $urandom_range(0, s),
						comp(p.lo, 2) + $urandom_range(0, s));
				p.a = near_point(p.lo, s);
				p.b = ($urandom_range(0, 15) == 0) ? p.a : near_point(p.a, s);
				p.c = near_point(p.a, s);
			end
			queue_pair(p);
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				queue_expected(predict_overlap(pending_pairs.pop_front()));
				send_gap = gap_length();
			end
			if (item_valid && !in_taken) begin
			end else if (send_gap > 0) begin
				send_gap--;
				item_valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				item_valid <= 1'b1;
				box_low_corner <= pending_pairs[0].lo;
				box_high_corner <= pending_pairs[0].hi;
				vertex_a <= pending_pairs[0].a;
				vertex_b <= pending_pairs[0].b;
				vertex_c <= pending_pairs[0].c;
			end else begin
				item_valid <= 1'b0;
				stimulus_done = 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (cycle_count == 300) hold_off = 60;
			if (hold_off > 0) begin
				hold_off--;
				result_stall <= 1'b1;
			end else if ($urandom_range(0, 29) == 0) begin
				hold_off = $urandom_range(5, 25);
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 3) == 0) && (cycle_count % 200 < 150);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		in_taken <= arst_n && item_valid && !item_stall;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_overlaps.size() == 0) begin
				$error("unexpected result overlaps=%0b", overlaps);
				failures++;
			end else if (overlaps !== expected_overlaps[0]) begin
				$error("overlaps: expected %0b, actual %0b", expected_overlaps[0], overlaps);
				failures++;
				void'(expected_overlaps.pop_front());
			end else begin
				void'(expected_overlaps.pop_front());
			end
		end
	end

	initial begin
		wait (stimulus_done && expected_overlaps.size() == 0);
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_overlaps.size() == 0)
			$display("** box_triangle_overlap_test_unit: PASSED **");
		else
			$display("** box_triangle_overlap_test_unit: FAILED **");
		$finish;
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("** box_triangle_overlap_test_unit: FAILED **");
		$finish;
	end

endmodule
